// ----- src/lcd4_pkg.sv -----
// Shared types, constants and the microcode program for the 4-bit LCD sequencer.
// No dependencies; used by lcd4_seq and char_lcd_4bit_interface_sequencer.
`default_nettype none

package lcd4_pkg;

    // Field widths
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HOLD_W   = 17;
    localparam int unsigned ENH_W    = 8;
    localparam int unsigned ENL_W    = 10;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned PC_W     = 5;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_CURSOR = 2'd3
    } t_opcode;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_ENABLE_LOW  = 2'd1;

    // Reset values of the timing registers
    localparam logic [ENH_W-1:0] ENABLE_HIGH_RST = 8'd3;
    localparam logic [ENL_W-1:0] ENABLE_LOW_RST  = 10'd50;

    // Fixed waits in microseconds
    localparam logic [HOLD_W-1:0] WAIT_POWER  = 17'd20000;
    localparam logic [HOLD_W-1:0] WAIT_FIRST  = 17'd5000;
    localparam logic [HOLD_W-1:0] WAIT_SECOND = 17'd100;
    localparam logic [HOLD_W-1:0] WAIT_CLEAR  = 17'd100000;

    // Initialization commands and cursor bases
    localparam logic [BYTE_W-1:0] CMD_WAKE     = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_HOME     = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_FUNC     = 8'h28;
    localparam logic [BYTE_W-1:0] CMD_DISP     = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_ENTRY    = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
    localparam logic [BYTE_W-1:0] DDRAM_LINE0  = 8'h80;
    localparam logic [BYTE_W-1:0] DDRAM_LINE1  = 8'hC0;

    // Program entry points
    localparam logic [PC_W-1:0] ENTRY_INIT = 5'd0;
    localparam logic [PC_W-1:0] ENTRY_BYTE = 5'd27;

    // Microcode fields
    typedef enum logic [1:0] {
        NIB_CONST,
        NIB_HI,
        NIB_LO
    } t_nib_sel;

    typedef enum logic [1:0] {
        BASE_NONE,
        BASE_HIGH,
        BASE_LOW
    } t_base_sel;

    typedef enum logic [2:0] {
        EXTRA_NONE,
        EXTRA_POWER,
        EXTRA_FIRST,
        EXTRA_SECOND,
        EXTRA_CLEAR
    } t_extra_sel;

    typedef struct packed {
        t_nib_sel             nib_sel;
        logic [NIB_W-1:0]     nib_const;
        logic                 en;
        t_base_sel            base_sel;
        t_extra_sel           extra_sel;
        logic                 last;
    } t_uword;

    // Builds one control word.
    function automatic t_uword uw(t_nib_sel sel, logic [NIB_W-1:0] nib, logic en,
                                  t_base_sel base, t_extra_sel extra, logic last);
        t_uword w;
        w.nib_sel   = sel;
        w.nib_const = nib;
        w.en        = en;
        w.base_sel  = base;
        w.extra_sel = extra;
        w.last      = last;
        return w;
    endfunction

    // The program: power-up initialization, then a shared byte routine.
    function automatic t_uword rom_word(logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            // Power-up wait with all pins low
            5'd0:  w = uw(NIB_CONST, 4'h0, 1'b0, BASE_NONE, EXTRA_POWER, 1'b0);
            // Three wake-up nibbles
            5'd1:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd2:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b0, BASE_LOW, EXTRA_FIRST, 1'b0);
            5'd3:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd4:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b0, BASE_LOW, EXTRA_SECOND, 1'b0);
            5'd5:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd6:  w = uw(NIB_CONST, CMD_WAKE[3:0], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            // Return home
            5'd7:  w = uw(NIB_CONST, CMD_HOME[7:4], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd8:  w = uw(NIB_CONST, CMD_HOME[7:4], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd9:  w = uw(NIB_CONST, CMD_HOME[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd10: w = uw(NIB_CONST, CMD_HOME[3:0], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            // Function set
            5'd11: w = uw(NIB_CONST, CMD_FUNC[7:4], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd12: w = uw(NIB_CONST, CMD_FUNC[7:4], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd13: w = uw(NIB_CONST, CMD_FUNC[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd14: w = uw(NIB_CONST, CMD_FUNC[3:0], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            // Display on
            5'd15: w = uw(NIB_CONST, CMD_DISP[7:4], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd16: w = uw(NIB_CONST, CMD_DISP[7:4], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd17: w = uw(NIB_CONST, CMD_DISP[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd18: w = uw(NIB_CONST, CMD_DISP[3:0], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            // Entry mode
            5'd19: w = uw(NIB_CONST, CMD_ENTRY[7:4], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd20: w = uw(NIB_CONST, CMD_ENTRY[7:4], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd21: w = uw(NIB_CONST, CMD_ENTRY[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd22: w = uw(NIB_CONST, CMD_ENTRY[3:0], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            // Clear display, with the long settle wait
            5'd23: w = uw(NIB_CONST, CMD_CLEAR[7:4], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd24: w = uw(NIB_CONST, CMD_CLEAR[7:4], 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd25: w = uw(NIB_CONST, CMD_CLEAR[3:0], 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd26: w = uw(NIB_CONST, CMD_CLEAR[3:0], 1'b0, BASE_LOW, EXTRA_CLEAR, 1'b1);
            // Byte routine for command, data and cursor requests
            5'd27: w = uw(NIB_HI, 4'h0, 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd28: w = uw(NIB_HI, 4'h0, 1'b0, BASE_LOW, EXTRA_NONE, 1'b0);
            5'd29: w = uw(NIB_LO, 4'h0, 1'b1, BASE_HIGH, EXTRA_NONE, 1'b0);
            5'd30: w = uw(NIB_LO, 4'h0, 1'b0, BASE_LOW, EXTRA_NONE, 1'b1);
            default: w = uw(NIB_CONST, 4'h0, 1'b0, BASE_NONE, EXTRA_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/lcd4_seq.sv -----
// Step counter and microcode table for the 4-bit LCD sequencer.
// Depends on lcd4_pkg for the control word type and the program.
`default_nettype none

module lcd4_seq (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [lcd4_pkg::PC_W-1:0]    i_entry,
    input  wire logic                         i_advance,
    output logic                              o_busy,
    output lcd4_pkg::t_uword                  o_uword
);

    logic [lcd4_pkg::PC_W-1:0] r_pc;
    logic [lcd4_pkg::PC_W-1:0] n_pc;
    logic                      r_busy;
    logic                      n_busy;

    // Current control word comes straight from the table.
    assign o_uword = lcd4_pkg::rom_word(r_pc);
    assign o_busy  = r_busy;

    // Start jumps to an entry point; the last word of a routine stops the program.
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = i_entry;
            n_busy = 1'b1;
        end else if (i_advance) begin
            if (o_uword.last) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

// ----- src/char_lcd_4bit_interface_sequencer.sv -----
// Top level of the 4-bit character LCD pin sequencer: request intake, timing
// registers, step datapath and output register. Depends on lcd4_pkg and lcd4_seq.
`default_nettype none

// Each accepted request becomes a run of pin-state items, one item per clock
// while the output side does not stall: 27 items for initialization, 4 for a
// command byte, a data character or a cursor move. The figure is set by the
// microcode step counter, which issues one control word per cycle unless the
// output side stalls. A request is taken only after the previous request's
// last item has entered the output register. Each item gives the data nibble,
// RS, RW (always write), EN and the time in microseconds to hold that pin
// state; the host is expected to do the actual waiting. Timing registers:
// index 0 is the enable-high time, index 1 the enable-low time; write them
// only while no request is in progress.

module char_lcd_4bit_interface_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [lcd4_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  wire logic [lcd4_pkg::CFG_W-1:0]        i_cfg_data,
    // Request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [lcd4_pkg::BYTE_W-1:0]       i_byte_value,
    input  wire logic                              i_row,
    input  wire logic [5:0]                        i_column,
    // Pin step channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [lcd4_pkg::NIB_W-1:0]             o_nibble,
    output logic                                   o_reg_select,
    output logic                                   o_read_write,
    output logic                                   o_enable_pin,
    output logic [lcd4_pkg::HOLD_W-1:0]            o_hold_us,
    output logic                                   o_last
);

    logic [lcd4_pkg::ENH_W-1:0]   r_enable_high;
    logic [lcd4_pkg::ENL_W-1:0]   r_enable_low;
    logic [lcd4_pkg::BYTE_W-1:0]  r_byte;
    logic                         r_rs;
    logic                         r_out_valid;
    logic [lcd4_pkg::NIB_W-1:0]   r_nibble;
    logic                         r_reg_select;
    logic                         r_enable_pin;
    logic [lcd4_pkg::HOLD_W-1:0]  r_hold_us;
    logic                         r_last;

    logic                         seq_busy;
    lcd4_pkg::t_uword             uword;
    logic                         in_take;
    logic                         advance;
    lcd4_pkg::t_opcode            op;
    logic [lcd4_pkg::PC_W-1:0]    entry;
    logic [lcd4_pkg::BYTE_W-1:0]  n_byte;
    logic [lcd4_pkg::NIB_W-1:0]   n_nibble;
    logic [lcd4_pkg::HOLD_W-1:0]  base_us;
    logic [lcd4_pkg::HOLD_W-1:0]  extra_us;
    logic [lcd4_pkg::HOLD_W-1:0]  n_hold_us;

    // Handshake: a request is taken only while the program is idle.
    assign o_in_stall = seq_busy;
    assign in_take    = i_in_valid && !seq_busy;
    assign advance    = seq_busy && (!r_out_valid || !i_out_stall);
    assign op         = lcd4_pkg::t_opcode'(i_opcode);

    // Request decode: entry point and the byte to send.
    always_comb begin
        unique case (op)
            lcd4_pkg::OP_INIT: begin
                entry  = lcd4_pkg::ENTRY_INIT;
                n_byte = i_byte_value;
            end
            lcd4_pkg::OP_CMD, lcd4_pkg::OP_DATA: begin
                entry  = lcd4_pkg::ENTRY_BYTE;
                n_byte = i_byte_value;
            end
            lcd4_pkg::OP_CURSOR: begin
                entry  = lcd4_pkg::ENTRY_BYTE;
                n_byte = (i_row ? lcd4_pkg::DDRAM_LINE1 : lcd4_pkg::DDRAM_LINE0)
                         + {2'b00, i_column};
            end
            default: begin
                entry  = lcd4_pkg::ENTRY_BYTE;
                n_byte = i_byte_value;
            end
        endcase
    end

    lcd4_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_take),
        .i_entry   (entry),
        .i_advance (advance),
        .o_busy    (seq_busy),
        .o_uword   (uword)
    );

    // Nibble selection from the control word.
    always_comb begin
        unique case (uword.nib_sel)
            lcd4_pkg::NIB_HI: n_nibble = r_byte[7:4];
            lcd4_pkg::NIB_LO: n_nibble = r_byte[3:0];
            default:          n_nibble = uword.nib_const;
        endcase
    end

    // Hold time is the selected timing register plus a fixed extra wait.
    always_comb begin
        unique case (uword.base_sel)
            lcd4_pkg::BASE_HIGH: base_us = lcd4_pkg::HOLD_W'(r_enable_high);
            lcd4_pkg::BASE_LOW:  base_us = lcd4_pkg::HOLD_W'(r_enable_low);
            default:             base_us = '0;
        endcase
        unique case (uword.extra_sel)
            lcd4_pkg::EXTRA_POWER:  extra_us = lcd4_pkg::WAIT_POWER;
            lcd4_pkg::EXTRA_FIRST:  extra_us = lcd4_pkg::WAIT_FIRST;
            lcd4_pkg::EXTRA_SECOND: extra_us = lcd4_pkg::WAIT_SECOND;
            lcd4_pkg::EXTRA_CLEAR:  extra_us = lcd4_pkg::WAIT_CLEAR;
            default:                extra_us = '0;
        endcase
        n_hold_us = base_us + extra_us;
    end

    // Timing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high <= lcd4_pkg::ENABLE_HIGH_RST;
            r_enable_low  <= lcd4_pkg::ENABLE_LOW_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == lcd4_pkg::CFG_ENABLE_HIGH) begin
                r_enable_high <= i_cfg_data[lcd4_pkg::ENH_W-1:0];
            end else if (i_cfg_index == lcd4_pkg::CFG_ENABLE_LOW) begin
                r_enable_low <= i_cfg_data[lcd4_pkg::ENL_W-1:0];
            end
        end
    end

    // Request payload held for the whole program run.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= n_byte;
            r_rs   <= (op == lcd4_pkg::OP_DATA);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_nibble     <= n_nibble;
            r_reg_select <= r_rs && (uword.nib_sel != lcd4_pkg::NIB_CONST);
            r_enable_pin <= uword.en;
            r_hold_us    <= n_hold_us;
            r_last       <= uword.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_nibble     = r_nibble;
    assign o_reg_select = r_reg_select;
    assign o_read_write = 1'b0;
    assign o_enable_pin = r_enable_pin;
    assign o_hold_us    = r_hold_us;
    assign o_last       = r_last;

endmodule

`default_nettype wire

// ----- sim/char_lcd_4bit_interface_sequencer_test.sv -----
// Self-checking testbench for the 4-bit character LCD pin sequencer.
// Depends on lcd4_pkg and char_lcd_4bit_interface_sequencer; drives a directed
// table and then random requests, and checks every pin step against a predictor.
`default_nettype none

module char_lcd_4bit_interface_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lcd4_pkg::*;

    // Datasheet waits and command bytes of the power-up sequence.
    localparam logic [HOLD_W-1:0] POWER_UP_WAIT  = 17'd20000;
    localparam logic [HOLD_W-1:0] AFTER_WAKE1    = 17'd5000;
    localparam logic [HOLD_W-1:0] AFTER_WAKE2    = 17'd100;
    localparam logic [HOLD_W-1:0] AFTER_CLEAR    = 17'd100000;
    localparam logic [HOLD_W-1:0] NO_EXTRA       = 17'd0;
    localparam logic [NIB_W-1:0]  WAKE_NIBBLE    = 4'h3;
    localparam logic [BYTE_W-1:0] RETURN_HOME    = 8'h02;
    localparam logic [BYTE_W-1:0] FUNCTION_SET   = 8'h28;
    localparam logic [BYTE_W-1:0] DISPLAY_ON     = 8'h0C;
    localparam logic [BYTE_W-1:0] ENTRY_MODE     = 8'h06;
    localparam logic [BYTE_W-1:0] CLEAR_DISPLAY  = 8'h01;
    localparam logic [BYTE_W-1:0] LINE0_ADDR     = 8'h80;
    localparam logic [BYTE_W-1:0] LINE1_ADDR     = 8'hC0;

    // A register index past the end of the register list.
    localparam logic [CFG_IX_W-1:0] CFG_NO_REG = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ITEMS_PER_SEG  = 24;

    typedef struct packed {
        t_opcode             opcode;
        logic [BYTE_W-1:0]   byte_value;
        logic                row;
        logic [5:0]          column;
    } t_request;

    typedef struct packed {
        logic [NIB_W-1:0]    nibble;
        logic                reg_select;
        logic                read_write;
        logic                enable_pin;
        logic [HOLD_W-1:0]   hold_us;
        logic                last;
    } t_pin_step;

    typedef enum logic {
        ROW_REQUEST,
        ROW_TIMING
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IX_W-1:0]    cfg_index;
        logic [CFG_W-1:0]       cfg_data;
        t_request               req;
        bit                     typed;
        t_pin_step              first;
    } t_directed_row;

    // Clock, reset and block inputs, all known from time zero.
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_wr_en  = 1'b0;
    logic [CFG_IX_W-1:0]    i_cfg_index  = '0;
    logic [CFG_W-1:0]       i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic [1:0]             i_opcode     = '0;
    logic [BYTE_W-1:0]      i_byte_value = '0;
    logic                   i_row        = 1'b0;
    logic [5:0]             i_column     = '0;
    logic                   i_out_stall  = 1'b0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [NIB_W-1:0]       o_nibble;
    logic                   o_reg_select;
    logic                   o_read_write;
    logic                   o_enable_pin;
    logic [HOLD_W-1:0]      o_hold_us;
    logic                   o_last;

    // Predictor copy of the timing registers and the steps still owed.
    logic [ENH_W-1:0]       timing_high = ENABLE_HIGH_RST;
    logic [ENL_W-1:0]       timing_low  = ENABLE_LOW_RST;
    t_pin_step              pending_steps[$];

    int                     tx_idle_pct     = 0;
    int                     rx_idle_pct     = 0;
    int                     mismatch_count  = 0;
    int                     requests_sent   = 0;
    int                     steps_checked   = 0;
    int                     timing_settings = 0;
    int                     quiet_cycles    = 0;
    t_directed_row          directed_rows[$];

    char_lcd_4bit_interface_sequencer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_nibble     (o_nibble),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable_pin (o_enable_pin),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Appends one expected pin state.
    function automatic void push_step(logic [NIB_W-1:0] nib, logic rs, logic en,
                                      logic [HOLD_W-1:0] hold);
        t_pin_step s;
        s.nibble     = nib;
        s.reg_select = rs;
        s.read_write = 1'b0;
        s.enable_pin = en;
        s.hold_us    = hold;
        s.last       = 1'b0;
        pending_steps.push_back(s);
    endfunction

    // One nibble is an enable-high step and an enable-low step.
    function automatic void push_strobe(logic [NIB_W-1:0] nib, logic rs,
                                        logic [HOLD_W-1:0] extra);
        push_step(nib, rs, 1'b1, HOLD_W'(timing_high));
        push_step(nib, rs, 1'b0, HOLD_W'(timing_low) + extra);
    endfunction

    // A byte goes out high nibble first; the extra wait follows the low nibble.
    function automatic void push_byte(logic [BYTE_W-1:0] b, logic rs,
                                      logic [HOLD_W-1:0] extra);
        push_strobe(b[7:4], rs, NO_EXTRA);
        push_strobe(b[3:0], rs, extra);
    endfunction

    // Predicts the pin steps of one accepted request and queues them.
    function automatic void expect_pin_steps(t_request req, bit typed, t_pin_step first);
        int                  base;
        logic [BYTE_W-1:0]   addr;
        t_pin_step           tail;
        base = pending_steps.size();
        unique case (req.opcode)
            OP_INIT: begin
                push_step(4'h0, 1'b0, 1'b0, POWER_UP_WAIT);
                push_strobe(WAKE_NIBBLE, 1'b0, AFTER_WAKE1);
                push_strobe(WAKE_NIBBLE, 1'b0, AFTER_WAKE2);
                push_strobe(WAKE_NIBBLE, 1'b0, NO_EXTRA);
                push_byte(RETURN_HOME, 1'b0, NO_EXTRA);
                push_byte(FUNCTION_SET, 1'b0, NO_EXTRA);
                push_byte(DISPLAY_ON, 1'b0, NO_EXTRA);
                push_byte(ENTRY_MODE, 1'b0, NO_EXTRA);
                push_byte(CLEAR_DISPLAY, 1'b0, AFTER_CLEAR);
            end
            OP_CMD:  push_byte(req.byte_value, 1'b0, NO_EXTRA);
            OP_DATA: push_byte(req.byte_value, 1'b1, NO_EXTRA);
            default: begin
                addr = (req.row ? LINE1_ADDR : LINE0_ADDR) + {2'b00, req.column};
                push_byte(addr, 1'b0, NO_EXTRA);
            end
        endcase
        tail = pending_steps.pop_back();
        tail.last = 1'b1;
        pending_steps.push_back(tail);
        // A step typed into the directed table replaces the predicted first one.
        if (typed) begin
            pending_steps[base] = first;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compares each accepted pin step with the oldest expected one.
    always @(posedge i_clk) begin
        t_pin_step want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_steps.size() == 0) begin
                $display("%0t ns: pin step with none expected, actual nibble %0h hold %0d",
                         $time, o_nibble, o_hold_us);
                mismatch_count++;
            end else begin
                want = pending_steps.pop_front();
                check_field("nibble", 32'(want.nibble), 32'(o_nibble));
                check_field("reg_select", 32'(want.reg_select), 32'(o_reg_select));
                check_field("read_write", 32'(want.read_write), 32'(o_read_write));
                check_field("enable_pin", 32'(want.enable_pin), 32'(o_enable_pin));
                check_field("hold_us", 32'(want.hold_us), 32'(o_hold_us));
                check_field("last", 32'(want.last), 32'(o_last));
                steps_checked++;
            end
        end
    end

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        i_out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // Ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Offers one request, with random gaps, and waits until it is accepted.
    task automatic send_request(input t_request req, input bit typed, input t_pin_step first);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= req.opcode;
        i_byte_value <= req.byte_value;
        i_row        <= req.row;
        i_column     <= req.column;
        do @(posedge i_clk); while (o_in_stall);
        expect_pin_steps(req, typed, first);
        requests_sent++;
    endtask

    // Waits until every expected step has come and the block has settled.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one timing register; the block must be idle.
    task automatic write_timing(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (ix == CFG_ENABLE_HIGH) begin
            timing_high = data[ENH_W-1:0];
        end else if (ix == CFG_ENABLE_LOW) begin
            timing_low = data[ENL_W-1:0];
        end
        timing_settings++;
        @(posedge i_clk);
    endtask

    function automatic t_directed_row dir_req(t_opcode op, logic [BYTE_W-1:0] b, logic r,
                                              logic [5:0] c, bit typed = 1'b0,
                                              logic [NIB_W-1:0] nib = '0, logic rs = 1'b0,
                                              logic en = 1'b0, logic [HOLD_W-1:0] hold = '0);
        t_directed_row d;
        d.kind           = ROW_REQUEST;
        d.cfg_index      = '0;
        d.cfg_data       = '0;
        d.req.opcode     = op;
        d.req.byte_value = b;
        d.req.row        = r;
        d.req.column     = c;
        d.typed          = typed;
        d.first          = '{nibble: nib, reg_select: rs, read_write: 1'b0,
                             enable_pin: en, hold_us: hold, last: 1'b0};
        return d;
    endfunction

    function automatic t_directed_row dir_cfg(logic [CFG_IX_W-1:0] ix, logic [CFG_W-1:0] data);
        t_directed_row d;
        d = dir_req(OP_INIT, '0, 1'b0, '0);
        d.kind      = ROW_TIMING;
        d.cfg_index = ix;
        d.cfg_data  = data;
        return d;
    endfunction

    function automatic t_request random_request();
        t_request req;
        req.opcode     = t_opcode'($urandom_range(3));
        req.byte_value = BYTE_W'($urandom_range(255));
        req.row        = 1'($urandom_range(1));
        // Mostly columns on the display, sometimes past its end.
        req.column     = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                  : 6'($urandom_range(39));
        return req;
    endfunction

    // Stimulus sequence.
    initial begin
        t_pin_step       none;
        logic [CFG_W-1:0] high_data;
        logic [CFG_W-1:0] low_data;
        int              setting;
        none = '0;

        // Directed rows; typed first steps use the reset timing (3 us, 50 us) at first.
        directed_rows.push_back(dir_req(OP_INIT,   8'h00, 1'b0, 6'd0,
                                        1'b1, 4'h0, 1'b0, 1'b0, 17'd20000));
        directed_rows.push_back(dir_req(OP_CMD,    8'h00, 1'b0, 6'd0,
                                        1'b1, 4'h0, 1'b0, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_CMD,    8'hFF, 1'b1, 6'd63,
                                        1'b1, 4'hF, 1'b0, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_DATA,   8'h00, 1'b1, 6'd63,
                                        1'b1, 4'h0, 1'b1, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_DATA,   8'hFF, 1'b0, 6'd0,
                                        1'b1, 4'hF, 1'b1, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_CURSOR, 8'h00, 1'b0, 6'd0,
                                        1'b1, 4'h8, 1'b0, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_CURSOR, 8'hFF, 1'b1, 6'd39,
                                        1'b1, 4'hE, 1'b0, 1'b1, 17'd3));
        // Columns past the end of a line are passed through.
        directed_rows.push_back(dir_req(OP_CURSOR, 8'h00, 1'b0, 6'd63,
                                        1'b1, 4'hB, 1'b0, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_CURSOR, 8'hFF, 1'b1, 6'd63,
                                        1'b1, 4'hF, 1'b0, 1'b1, 17'd3));
        directed_rows.push_back(dir_req(OP_CURSOR, 8'hA5, 1'b0, 6'd21));
        // Both timing registers at zero leave only the fixed waits.
        directed_rows.push_back(dir_cfg(CFG_ENABLE_HIGH, 10'd0));
        directed_rows.push_back(dir_cfg(CFG_ENABLE_LOW, 10'd0));
        directed_rows.push_back(dir_req(OP_INIT,   8'h5A, 1'b1, 6'd7,
                                        1'b1, 4'h0, 1'b0, 1'b0, 17'd20000));
        directed_rows.push_back(dir_req(OP_CMD,    8'h5A, 1'b0, 6'd0,
                                        1'b1, 4'h5, 1'b0, 1'b1, 17'd0));
        // Full-width writes: the enable-high register keeps only its low byte.
        directed_rows.push_back(dir_cfg(CFG_ENABLE_HIGH, 10'h3FF));
        directed_rows.push_back(dir_cfg(CFG_ENABLE_LOW, 10'h3FF));
        // A write to an index past the register list changes nothing.
        directed_rows.push_back(dir_cfg(CFG_NO_REG, 10'h2AA));
        directed_rows.push_back(dir_req(OP_INIT,   8'h00, 1'b0, 6'd0));
        directed_rows.push_back(dir_req(OP_DATA,   8'h3C, 1'b0, 6'd0,
                                        1'b1, 4'h3, 1'b1, 1'b1, 17'd255));
        directed_rows.push_back(dir_cfg(CFG_ENABLE_HIGH, 10'd1));
        directed_rows.push_back(dir_cfg(CFG_ENABLE_LOW, 10'd1));
        directed_rows.push_back(dir_req(OP_CMD,    8'h81, 1'b0, 6'd0,
                                        1'b1, 4'h8, 1'b0, 1'b1, 17'd1));
        directed_rows.push_back(dir_req(OP_CURSOR, 8'h00, 1'b1, 6'd5));
        directed_rows.push_back(dir_req(OP_DATA,   8'hC3, 1'b1, 6'd42));

        // Synchronous reset at the start.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 36;
        rx_idle_pct = 88;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_TIMING) begin
                wait_drained();
                write_timing(directed_rows[k].cfg_index, directed_rows[k].cfg_data);
            end else begin
                send_request(directed_rows[k].req, directed_rows[k].typed,
                             directed_rows[k].first);
            end
        end

        // Random part: three idling patterns, each with three timing settings.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 88 : 0;
            rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 36 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                setting = phase * 3 + seg;
                if (setting == 0) begin
                    high_data = 10'd1;
                    low_data  = 10'd1;
                end else if (setting == 1) begin
                    high_data = 10'd255;
                    low_data  = 10'd1023;
                end else begin
                    high_data = CFG_W'($urandom_range(1023));
                    low_data  = CFG_W'($urandom_range(1023));
                end
                wait_drained();
                write_timing(CFG_ENABLE_HIGH, high_data);
                write_timing(CFG_ENABLE_LOW, low_data);
                for (int n = 0; n < ITEMS_PER_SEG; n++) begin
                    send_request(random_request(), 1'b0, none);
                end
            end
        end

        wait_drained();
        repeat (3 * SETTLE_CYCLES) @(posedge i_clk);
        if (pending_steps.size() != 0) begin
            $display("%0t ns: expected %0d more pin steps, actual 0",
                     $time, pending_steps.size());
            mismatch_count++;
        end

        $display("Ran %0d requests giving %0d checked pin steps, under three stall patterns",
                 requests_sent, steps_checked);
        $display("and %0d timing register writes, zero and full-scale values included.",
                 timing_settings);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/lcd4_pkg.sv
src/lcd4_seq.sv
src/char_lcd_4bit_interface_sequencer.sv
sim/char_lcd_4bit_interface_sequencer_test.sv
